// ===== hdl/pwl_pkg.sv =====
// Package for the piecewise-linear table lookup.
// Holds the field widths, the command codes and the sequencer state type.
// No dependencies.
package pwl_pkg;

  // Field widths fixed by the item format.
  localparam int CMD_W   = 1;
  localparam int INDEX_W = 4;
  localparam int DATA_W  = 8;
  localparam int CFG_W   = 5;

  // Command codes of an input transaction.
  localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

  // Reset value of the points-in-use register.
  localparam logic [CFG_W-1:0] POINTS_RESET = 5'd2;

  // Query sequencer states, one-hot.
  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_CHK_LO  = 11'b000_0000_0010,
    S_CHK_HI  = 11'b000_0000_0100,
    S_SEARCH  = 11'b000_0000_1000,
    S_CHK_MID = 11'b000_0001_0000,
    S_SEG0    = 11'b000_0010_0000,
    S_SEG1    = 11'b000_0100_0000,
    S_MUL     = 11'b000_1000_0000,
    S_DIV     = 11'b001_0000_0000,
    S_FIN     = 11'b010_0000_0000,
    S_DONE    = 11'b100_0000_0000
  } state_t;

endpackage

// ===== hdl/pwl_if.sv =====
// Channel interfaces of the piecewise-linear table lookup.
// Depends on pwl_pkg for the field widths.
interface pwl_in_if;
  import pwl_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [INDEX_W-1:0] point_index;
  logic [DATA_W-1:0]  point_x;
  logic [DATA_W-1:0]  point_y;
  logic [DATA_W-1:0]  query_value;

  modport source (output valid, command, point_index, point_x, point_y, query_value,
                  input ready);
  modport sink   (input valid, command, point_index, point_x, point_y, query_value,
                  output ready);
endinterface

interface pwl_out_if;
  import pwl_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] result_value;
  logic              clamped;

  modport source (output valid, result_value, clamped, input ready);
  modport sink   (input valid, result_value, clamped, output ready);
endinterface

// ===== hdl/piecewise_linear_table_lookup.sv =====
// Top level of the piecewise-linear table lookup.
// Depends on pwl_pkg and on the channel interfaces in pwl_if.sv.
//
// Usage:
//   in_ch carries load and query transactions. A load writes one breakpoint
//   (x, y) into the slot point_index and is finished in the cycle it is
//   accepted; it gives no result. A query looks up query_value and gives one
//   transaction on out_ch with the exact or interpolated y and a clamped flag
//   that is set when the value lay outside the table's x span.
//   cfg_we / cfg_wdata write the points-in-use register (reset value 2); it
//   is used saturated to 2..MAX_POINTS. The user must write it only while
//   idle; the block itself does not enforce this.
//   A query runs on a sequencer around one table read port, one 8x8
//   multiplier and a one-bit-per-cycle restoring divider. Each table read
//   is registered. A clamped query ends after the low or high bound check;
//   an interpolated query runs the bound checks, the binary search, the
//   segment set-up, the multiply, the divider steps and the final add.
//   in_ch.ready is low while a query is busy.
//
//   Reset clears the sequencer, the output valid flag and points_in_use; the
//   breakpoint table is not cleared and must be loaded before it is queried.
//   When the receiver stalls, a result waits in the output register; the
//   block still takes the next transaction and holds a new result internally
//   until the output register is free.
module piecewise_linear_table_lookup #(
  parameter int MAX_POINTS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [pwl_pkg::CFG_W-1:0] cfg_wdata,
  pwl_in_if.sink                    in_ch,
  pwl_out_if.source                 out_ch
);
  import pwl_pkg::*;

  localparam int IW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

  state_t state;

  // Configuration and per-query registers.
  logic [CFG_W-1:0]  points_in_use;
  logic [IW-1:0]     last_idx;
  logic [DATA_W-1:0] qval;
  logic [IW-1:0]     lo;
  logic [IW-1:0]     hi;
  logic [DATA_W-1:0] seg_x0;
  logic [DATA_W-1:0] seg_y0;
  logic [DATA_W-1:0] dx;
  logic [DATA_W-1:0] dv;
  logic [DATA_W-1:0] dy;
  logic              neg;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [2:0]        div_cnt;
  logic [DATA_W-1:0] res_value;
  logic              res_clamped;

  // Output register.
  logic              out_valid;
  logic [DATA_W-1:0] out_value;
  logic              out_clamped;

  // Breakpoint table.
  logic [DATA_W-1:0] x_mem [MAX_POINTS];
  logic [DATA_W-1:0] y_mem [MAX_POINTS];
  logic [DATA_W-1:0] rd_x;
  logic [DATA_W-1:0] rd_y;
  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     wr_addr;
  logic              load_write;

  // Combinational helpers.
  logic              in_accept;
  logic [31:0]       cfg_ext;
  logic [IW-1:0]     last_idx_next;
  logic [IW:0]       mid_sum;
  logic [IW-1:0]     mid;
  logic              search_more;
  logic [DATA_W-1:0] dx_c;
  logic [DATA_W-1:0] dv_raw;
  logic [DATA_W-1:0] dv_c;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   trial_diff;
  logic              trial_ge;
  logic              out_free;

  assign in_ch.ready    = (state == S_IDLE);
  assign in_accept      = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.result_value = out_value;
  assign out_ch.clamped = out_clamped;
  assign out_free       = !out_valid || out_ch.ready;

  // Load address and range check.
  assign wr_addr    = IW'(in_ch.point_index);
  assign load_write = in_accept && (in_ch.command == CMD_LOAD) &&
                      (32'(in_ch.point_index) < 32'(MAX_POINTS));

  // Last index searched: points_in_use saturated to 2..MAX_POINTS, minus one.
  always_comb begin
    cfg_ext = 32'(points_in_use);
    if (cfg_ext < 32'd2) begin
      last_idx_next = IW'(1);
    end else if (cfg_ext > 32'(MAX_POINTS)) begin
      last_idx_next = IW'(MAX_POINTS - 1);
    end else begin
      last_idx_next = IW'(cfg_ext - 32'd1);
    end
  end

  // Binary search midpoint and end test.
  assign mid_sum     = {1'b0, lo} + {1'b0, hi};
  assign mid         = mid_sum[IW:1];
  assign search_more = ({1'b0, hi} - {1'b0, lo}) > (IW+1)'(1);

  // Segment set-up from the upper breakpoint.
  assign dx_c   = rd_x - seg_x0;
  assign dv_raw = (qval > seg_x0) ? (qval - seg_x0) : '0;
  assign dv_c   = (dv_raw > dx_c) ? dx_c : dv_raw;

  // One restoring division step.
  assign trial      = {rem, quo[DATA_W-1]};
  assign trial_ge   = trial >= {1'b0, dx};
  assign trial_diff = trial - {1'b0, dx};

  // Table read address for the next cycle.
  always_comb begin
    unique case (state)
      S_CHK_LO: rd_addr = last_idx;
      S_SEARCH: rd_addr = search_more ? mid : lo;
      S_SEG0:   rd_addr = lo + IW'(1);
      default:  rd_addr = '0;
    endcase
  end

  // Breakpoint memory with a registered read port.
  always_ff @(posedge clk) begin
    if (load_write) begin
      x_mem[wr_addr] <= in_ch.point_x;
      y_mem[wr_addr] <= in_ch.point_y;
    end
    rd_x <= x_mem[rd_addr];
    rd_y <= y_mem[rd_addr];
  end

  // Control: sequencer, configuration register and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      points_in_use <= POINTS_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        points_in_use <= cfg_wdata;
      end
      // A finished result fills the output register; a taken one empties it.
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept && (in_ch.command == CMD_QUERY)) begin
            state <= S_CHK_LO;
          end
        end
        S_CHK_LO: begin
          state <= (qval < rd_x) ? S_DONE : S_CHK_HI;
        end
        S_CHK_HI: begin
          state <= (qval > rd_x) ? S_DONE : S_SEARCH;
        end
        S_SEARCH: begin
          state <= search_more ? S_CHK_MID : S_SEG0;
        end
        S_CHK_MID: begin
          state <= (qval == rd_x) ? S_DONE : S_SEARCH;
        end
        S_SEG0: begin
          state <= (qval == rd_x) ? S_DONE : S_SEG1;
        end
        S_SEG1: begin
          state <= (rd_x <= seg_x0) ? S_DONE : S_MUL;
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_cnt == 3'd7) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers of the query.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        qval     <= in_ch.query_value;
        last_idx <= last_idx_next;
      end
      S_CHK_LO: begin
        res_value   <= rd_y;
        res_clamped <= 1'b1;
      end
      S_CHK_HI: begin
        res_value   <= rd_y;
        res_clamped <= (qval > rd_x);
        lo          <= '0;
        hi          <= last_idx;
      end
      S_SEARCH: begin
      end
      S_CHK_MID: begin
        res_value <= rd_y;
        if (qval > rd_x) begin
          lo <= mid;
        end else if (qval < rd_x) begin
          hi <= mid;
        end
      end
      S_SEG0: begin
        seg_x0    <= rd_x;
        seg_y0    <= rd_y;
        res_value <= rd_y;
      end
      S_SEG1: begin
        dx  <= dx_c;
        dv  <= dv_c;
        neg <= !(rd_y > seg_y0);
        dy  <= (rd_y > seg_y0) ? (rd_y - seg_y0) : (seg_y0 - rd_y);
      end
      S_MUL: begin
        {rem, quo} <= dv * dy;
        div_cnt    <= '0;
      end
      S_DIV: begin
        rem     <= trial_ge ? trial_diff[DATA_W-1:0] : trial[DATA_W-1:0];
        quo     <= {quo[DATA_W-2:0], trial_ge};
        div_cnt <= div_cnt + 3'd1;
      end
      S_FIN: begin
        res_value <= neg ? (seg_y0 - quo) : (seg_y0 + quo);
      end
      S_DONE: begin
        if (out_free) begin
          out_value   <= res_value;
          out_clamped <= res_clamped;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/pwl_checker.sv =====
// Port-level checker for the piecewise-linear table lookup.
// Watches only the top level's ports; bound to the top level below.
module pwl_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_command,
  input logic out_valid,
  input logic out_ready,
  input logic [7:0] out_result_value,
  input logic out_clamped
);
  import pwl_pkg::*;

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_result_value) && $stable(out_clamped))
    else $error("result payload changed while stalled");

  // An accepted query keeps the input side busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_command == CMD_QUERY) |=> !in_ready)
    else $error("input ready right after a query transaction");

  // A load finishes at once and produces no result.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_command == CMD_LOAD) && !out_valid |=> in_ready && !out_valid)
    else $error("load transaction produced a result or stalled the input");

endmodule

bind piecewise_linear_table_lookup pwl_checker u_pwl_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_command       (in_ch.command),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_result_value (out_ch.result_value),
  .out_clamped      (out_ch.clamped)
);

// ===== verif/piecewise_linear_table_lookup_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the piecewise-linear table lookup.
// Depends on pwl_pkg, the channel interfaces in pwl_if.sv and the top level.
module piecewise_linear_table_lookup_tb;
  import pwl_pkg::*;

  localparam int MAX_POINTS    = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_COUNT   = 12;

  // One input transaction as the stimulus plans it.
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [INDEX_W-1:0] point_index;
    logic [DATA_W-1:0]  point_x;
    logic [DATA_W-1:0]  point_y;
    logic [DATA_W-1:0]  query_value;
  } table_op_t;

  // One output transaction.
  typedef struct packed {
    logic [DATA_W-1:0] result_value;
    logic              clamped;
  } lookup_result_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  pwl_in_if  in_ch ();
  pwl_out_if out_ch ();

  piecewise_linear_table_lookup #(
    .MAX_POINTS(MAX_POINTS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  table_op_t      op_queue[$];
  lookup_result_t expected_lookups[$];
  table_op_t      next_op;
  lookup_result_t oldest_lookup;

  // Breakpoints as the block holds them (updated on acceptance) and as the
  // stimulus has planned them (updated when queued).
  logic [DATA_W-1:0] model_x [MAX_POINTS];
  logic [DATA_W-1:0] model_y [MAX_POINTS];
  logic [DATA_W-1:0] plan_x  [MAX_POINTS];
  logic [CFG_W-1:0]  points_setting;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;

  // The register is used saturated to 2..MAX_POINTS.
  function automatic int active_points(logic [CFG_W-1:0] setting);
    if (setting < 2) return 2;
    if (setting > MAX_POINTS) return MAX_POINTS;
    return int'(setting);
  endfunction

  // Clamp, binary search and truncating interpolation over the held table.
  function automatic lookup_result_t interpolate(logic [DATA_W-1:0] value);
    int n, lo, hi, mid, v, x0, y0, x1, y1, dx, dv;
    bit hit;
    lookup_result_t r;
    n = active_points(points_setting);
    v = int'(value);
    r.clamped = 1'b0;
    if (value < model_x[0]) begin
      r.result_value = model_y[0];
      r.clamped = 1'b1;
    end else if (value > model_x[n-1]) begin
      r.result_value = model_y[n-1];
      r.clamped = 1'b1;
    end else begin
      lo = 0;
      hi = n - 1;
      hit = 1'b0;
      while (!hit && hi - lo > 1) begin
        mid = (lo + hi) / 2;
        if (value > model_x[mid]) lo = mid;
        else if (value < model_x[mid]) hi = mid;
        else begin
          lo = mid;
          hit = 1'b1;
        end
      end
      x0 = int'(model_x[lo]);
      y0 = int'(model_y[lo]);
      x1 = int'(model_x[lo+1]);
      y1 = int'(model_y[lo+1]);
      if (x0 == v || x1 <= x0) begin
        r.result_value = DATA_W'(y0);
      end else begin
        // The distance is kept inside the segment, so the result lies between y0 and y1.
        dx = x1 - x0;
        dv = (v > x0) ? v - x0 : 0;
        if (dv > dx) dv = dx;
        if (y1 > y0) r.result_value = DATA_W'(y0 + (dv * (y1 - y0)) / dx);
        else r.result_value = DATA_W'(y0 - (dv * (y0 - y1)) / dx);
      end
    end
    return r;
  endfunction

  function automatic int random_y();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic add_load(int slot, int x, int y);
    table_op_t op;
    op.command     = CMD_LOAD;
    op.point_index = INDEX_W'(slot);
    op.point_x     = DATA_W'(x);
    op.point_y     = DATA_W'(y);
    op.query_value = DATA_W'($urandom_range(0, 255));
    op_queue.push_back(op);
    plan_x[slot] = DATA_W'(x);
  endtask

  task automatic add_query(int v);
    table_op_t op;
    op.command     = CMD_QUERY;
    op.point_index = INDEX_W'($urandom_range(0, MAX_POINTS - 1));
    op.point_x     = DATA_W'($urandom_range(0, 255));
    op.point_y     = DATA_W'($urandom_range(0, 255));
    op.query_value = DATA_W'(v);
    op_queue.push_back(op);
  endtask

  // Mostly exact hits and values inside the span, some anywhere.
  task automatic add_random_query();
    int n;
    n = active_points(points_setting);
    case ($urandom_range(0, 9))
      0, 1, 2, 3:    add_query(int'(plan_x[$urandom_range(0, n - 1)]));
      4, 5, 6, 7:    add_query($urandom_range(int'(plan_x[0]), int'(plan_x[n-1])));
      default:       add_query($urandom_range(0, 255));
    endcase
  endtask

  // Fills all slots, with strictly rising x of random density or with
  // arbitrary x that may repeat or fall.
  task automatic load_table(bit rising);
    int x, cap, density;
    density = $urandom_range(1, 3);
    x = $urandom_range(0, 40);
    for (int k = 0; k < MAX_POINTS; k++) begin
      if (rising) begin
        add_load(k, x, random_y());
        if (k < MAX_POINTS - 1) begin
          cap = (255 - x) / (MAX_POINTS - 1 - k);
          if (density == 1 && cap > 3) cap = 3;
          if (density == 2 && cap > 12) cap = 12;
          x = x + $urandom_range(1, cap);
        end
      end else begin
        add_load(k, $urandom_range(0, 255), random_y());
      end
    end
  endtask

  // Waits until every transaction is through and the sequencer has settled.
  task automatic wait_idle();
    while (op_queue.size() != 0 || in_ch.valid || expected_lookups.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_points(int value);
    @(posedge clk);
    cfg_we         <= 1'b1;
    cfg_wdata      <= CFG_W'(value);
    points_setting = CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: presents queued transactions and updates the prediction on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        if (in_ch.command == CMD_LOAD) begin
          model_x[in_ch.point_index] = in_ch.point_x;
          model_y[in_ch.point_index] = in_ch.point_y;
        end else begin
          expected_lookups.push_back(interpolate(in_ch.query_value));
        end
      end
      if (op_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_op = op_queue.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.command     <= next_op.command;
        in_ch.point_index <= next_op.point_index;
        in_ch.point_x     <= next_op.point_x;
        in_ch.point_y     <= next_op.point_y;
        in_ch.query_value <= next_op.query_value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transaction against the oldest expected lookup.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_lookups.size() == 0) begin
          $display("%0t: unexpected result value %0d clamped %0d", $time,
                   out_ch.result_value, out_ch.clamped);
          mismatches++;
        end else begin
          oldest_lookup = expected_lookups.pop_front();
          if (out_ch.result_value !== oldest_lookup.result_value) begin
            $display("%0t: result_value expected %0d actual %0d", $time,
                     oldest_lookup.result_value, out_ch.result_value);
            mismatches++;
          end
          if (out_ch.clamped !== oldest_lookup.clamped) begin
            $display("%0t: clamped expected %0d actual %0d", $time,
                     oldest_lookup.clamped, out_ch.clamped);
            mismatches++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Stimulus and end of run.
  initial begin
    int settings [PHASE_COUNT];
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    points_setting    = POINTS_RESET;
    mismatches        = 0;
    send_idle_pct     = 37;
    recv_idle_pct     = 66;
    settings = '{2, 3, 0, 16, 31, 7, 1, 9, 17, 4, 15, 0};
    settings[PHASE_COUNT-1] = $urandom_range(0, 31);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: full table with alternating full-swing y, so segments rise and fall.
    write_points(MAX_POINTS);
    for (int k = 0; k < MAX_POINTS; k++)
      add_load(k, 5 + 16 * k, (k % 2 == 0) ? 0 : 255);
    // A repeated x gives a zero-width segment.
    add_load(2, 21, 128);
    add_query(0);     // below the span
    add_query(255);   // above the span
    add_query(5);     // exact hit on the first point
    add_query(245);   // exact hit on the last point
    add_query(13);    // rising segment
    add_query(21);    // exact hit on the repeated x
    add_query(29);    // after the zero-width segment
    add_query(100);   // falling segment
    add_query(200);

    // Random phases, each under its own setting of points in use.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_idle();
      if (phase == 4) begin
        send_idle_pct = 66;
        recv_idle_pct = 37;
      end else if (phase == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_points(settings[phase]);
      load_table($urandom_range(0, 3) != 0);
      repeat (30) begin
        if ($urandom_range(0, 6) == 0) begin
          int slot;
          slot = $urandom_range(0, MAX_POINTS - 1);
          add_load(slot, $urandom_range(0, 1) ? int'(plan_x[slot]) : $urandom_range(0, 255),
                   random_y());
        end else begin
          add_random_query();
        end
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/pwl_pkg.sv
hdl/pwl_if.sv
hdl/piecewise_linear_table_lookup.sv
hdl/pwl_checker.sv
verif/piecewise_linear_table_lookup_tb.sv
